### hw/rtl/assert_macros.svh
// Assertion helper used by ckd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define CKD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### hw/rtl/ckd_pkg.sv
package ckd_pkg;
    localparam int MaxPoints = 1024;
    localparam int CodeBits  = 24;
    localparam int CoordW    = 32;
    localparam int SizeW     = 11;
    localparam int CfgIdxW   = 2;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_ACCESS = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_TREE_SIZE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture item, reset walk to root
        logic rd;        // issue memory read at mid
        logic sqrt_init; // start root iteration on read data
        logic sqrt_step; // one root bit
        logic div_init;  // prepare zone compare
        logic decode;    // form node point
        logic advance;   // narrow range, move parent
        logic finish;    // latch result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic range_ok;  // lo <= hi
        logic sqrt_done;
        logic hit;       // node equals target
        logic idx_ok;    // access index in range
    } t_sts;
endpackage

### hw/rtl/ckd_datapath.sv
module ckd_datapath #(
    parameter int MAX_POINTS = ckd_pkg::MaxPoints,
    parameter int CODE_BITS  = ckd_pkg::CodeBits
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ckd_pkg::t_cmd               i_cmd,
    output ckd_pkg::t_sts               o_sts,
    input  logic [1:0]                  i_opcode,
    input  logic [ckd_pkg::SizeW-1:0]   i_entry_index,
    input  logic [CODE_BITS-1:0]        i_code_value,
    input  logic [ckd_pkg::CoordW-1:0]  i_query_x,
    input  logic [ckd_pkg::CoordW-1:0]  i_query_y,
    input  logic                        i_wr,
    input  logic [ckd_pkg::CoordW-1:0]  i_origin_x,
    input  logic [ckd_pkg::CoordW-1:0]  i_origin_y,
    input  logic [ckd_pkg::SizeW-1:0]   i_tree_size,
    output logic                        o_found,
    output logic [ckd_pkg::CoordW-1:0]  o_point_x,
    output logic [ckd_pkg::CoordW-1:0]  o_point_y
);
    import ckd_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PW = (($clog2(MAX_POINTS + 2) > SizeW) ? $clog2(MAX_POINTS + 2)
                                                          : SizeW) + 1;
    localparam int CW = CODE_BITS;
    localparam int RW = (CW + 1) / 2 + 1;
    localparam int SQ_STEPS = (CW + 1) / 2;
    localparam int SW = $clog2(SQ_STEPS + 1);

    logic [CW-1:0] r_mem [MAX_POINTS];
    logic [CW-1:0] r_code;

    logic [1:0]  r_op;
    logic [PW-1:0] r_idx, r_lo, r_hi, r_used;
    logic [CoordW-1:0] r_qx, r_qy, r_px, r_py, r_nx, r_ny;
    logic r_splitx;

    logic [CW+1:0] r_rem;
    logic [CW+1:0] r_res;
    logic [SW-1:0] r_cnt;

    logic [CW+1:0] r_d, r_l1;
    logic [RW:0]   r_m;

    logic r_found;
    logic [CoordW-1:0] r_ox, r_oy;

    logic [PW-1:0] w_mid, w_wi;
    logic [CW+1:0] w_bit, w_try;
    logic [RW:0]   w_len;
    logic [2*RW+3:0] w_sq;

    // Write port and registered read
    assign w_wi = PW'(i_entry_index);
    always_ff @(posedge i_clk) begin
        if (i_wr && i_opcode == OP_WRITE && w_wi >= PW'(1) && w_wi <= PW'(MAX_POINTS)) begin
            r_mem[AW'(w_wi - PW'(1))] <= i_code_value;
        end
        if (i_cmd.rd) begin
            r_code <= r_mem[AW'(w_mid - PW'(1))];
        end
    end

    assign w_mid = (r_lo + r_hi) >> 1;
    assign w_bit = (CW+2)'(1) << (2 * (SQ_STEPS - 1 - int'(r_cnt)));
    assign w_try = r_res + w_bit;
    assign w_len = (RW+1)'(r_res) + (RW+1)'(1) + (RW+1)'(r_res[0]);
    assign w_sq  = (2*RW+4)'(w_len - (RW+1)'(2)) * (2*RW+4)'(w_len - (RW+1)'(2));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_idx  <= PW'(i_entry_index);
            r_qx   <= i_query_x;
            r_qy   <= i_query_y;
            r_px   <= i_origin_x;
            r_py   <= i_origin_y;
            r_lo   <= PW'(1);
            r_used <= (int'(i_tree_size) > MAX_POINTS) ? PW'(MAX_POINTS) : PW'(i_tree_size);
            r_hi   <= (int'(i_tree_size) > MAX_POINTS) ? PW'(MAX_POINTS) : PW'(i_tree_size);
            r_splitx <= 1'b1;
        end
        if (i_cmd.sqrt_init) begin
            r_rem <= (CW+2)'(r_code);
            r_res <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.sqrt_step) begin
            // Restoring square root, one result bit per step
            if (r_rem >= w_try) begin
                r_rem <= r_rem - w_try;
                r_res <= (r_res >> 1) + w_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_cnt <= r_cnt + SW'(1);
        end
        if (i_cmd.div_init) begin
            r_m  <= (w_len - (RW+1)'(1)) >> 1;
            r_l1 <= (CW+2)'(w_len - (RW+1)'(1));
            r_d  <= (CW+2)'(r_code) - (CW+2)'(w_sq);
        end
        if (i_cmd.decode) begin
            // d < 4*(len-1), so zone comes from three compares
            if (r_code == '0) begin
                r_nx <= r_px;
                r_ny <= r_py;
            end else if (r_d < r_l1) begin
                r_nx <= r_px + CoordW'(r_m);
                r_ny <= r_py + CoordW'(r_m) - CoordW'(r_d);
            end else if (r_d < (r_l1 << 1)) begin
                r_nx <= r_px + CoordW'(r_l1) + CoordW'(r_m) - CoordW'(r_d);
                r_ny <= r_py - CoordW'(r_m);
            end else if (r_d < (r_l1 << 1) + r_l1) begin
                r_nx <= r_px - CoordW'(r_m);
                r_ny <= r_py + CoordW'(r_d) - CoordW'(r_m) - CoordW'(r_l1 << 1);
            end else begin
                r_nx <= r_px + CoordW'(r_d) - CoordW'(r_m) - CoordW'((r_l1 << 1) + r_l1);
                r_ny <= r_py + CoordW'(r_m);
            end
        end
        if (i_cmd.advance) begin
            if (r_op == OP_LOOKUP) begin
                if (r_splitx ? ($signed(r_qx) <= $signed(r_nx))
                             : ($signed(r_qy) <= $signed(r_ny))) r_hi <= w_mid - PW'(1);
                else r_lo <= w_mid + PW'(1);
            end else begin
                if (r_idx < w_mid) r_hi <= w_mid - PW'(1);
                else r_lo <= w_mid + PW'(1);
            end
            r_px <= r_nx;
            r_py <= r_ny;
            r_splitx <= ~r_splitx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.finish) begin
            r_found <= o_sts.hit && o_sts.range_ok;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (o_sts.hit && o_sts.range_ok) begin
                r_ox <= r_nx;
                r_oy <= r_ny;
            end else begin
                r_ox <= '0;
                r_oy <= '0;
            end
        end
    end

    assign o_sts.range_ok  = r_lo <= r_hi;
    assign o_sts.sqrt_done = r_cnt == SW'(SQ_STEPS);
    assign o_sts.hit = (r_op == OP_LOOKUP) ? (r_nx == r_qx && r_ny == r_qy) : (w_mid == r_idx);
    assign o_sts.idx_ok = r_idx >= PW'(1) && r_idx <= r_used;

    assign o_found   = r_found;
    assign o_point_x = r_ox;
    assign o_point_y = r_oy;
endmodule

### hw/rtl/ckd_ctrl.sv
module ckd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_fire,
    input  logic [1:0]    i_opcode,
    input  ckd_pkg::t_sts i_sts,
    output ckd_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_res_valid,
    input  logic          i_res_ready
);
    import ckd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_DATA  = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_DEC   = 4'd6;
    localparam logic [3:0] S_TEST  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state, n_state;
    logic r_access, n_access;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_access <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_access <= n_access;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_access = r_access;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_fire && (i_opcode == OP_LOOKUP || i_opcode == OP_ACCESS)) begin
                    o_cmd.load = 1'b1;
                    n_access   = i_opcode == OP_ACCESS;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.range_ok || (r_access && !i_sts.idx_ok)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DATA;
            end
            S_DATA: begin
                o_cmd.sqrt_init = 1'b1;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (i_sts.sqrt_done) n_state = S_PREP;
                else o_cmd.sqrt_step = 1'b1;
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decode = 1'b1;
                n_state = S_TEST;
            end
            S_TEST: begin
                if (i_sts.hit) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy      = r_state != S_IDLE;
    assign o_res_valid = r_state == S_OUT;
endmodule

### hw/rtl/compact_kd_tree_point_lookup.sv
// Sequence: lookup and access, at each tree level, do a bounds check, memory read,
//   data capture, square-root steps, ring setup, decode and compare; at most 11 levels
//   for 1024 points.
// Throughput: one item at a time; writes and unused opcodes give no result and leave
//   the input ready; after a result transfer the input is ready again on the next cycle.
// Reset: synchronous active-low; clears control and configuration, code memory
//   holds its contents and is undefined until written.
module compact_kd_tree_point_lookup #(
    parameter int MAX_POINTS = ckd_pkg::MaxPoints,
    parameter int CODE_BITS  = ckd_pkg::CodeBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: opcode[1:0], entry_index[12:2], code_value, query_x, query_y, zero fill
    input  logic [((2 + ckd_pkg::SizeW + CODE_BITS + 64 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: found[0], point_x[32:1], point_y[64:33], zero fill
    output logic [71:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [ckd_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import ckd_pkg::*;

    localparam int QX = 2 + SizeW + CODE_BITS;

    logic [CoordW-1:0] r_origin_x, r_origin_y;
    logic [SizeW-1:0]  r_tree_size;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy, w_fire, w_found;
    logic [CoordW-1:0] w_px, w_py;

    // Hold configuration; it is to be written only while idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_tree_size <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:  r_origin_x  <= i_cfg_data;
                CFG_ORIGIN_Y:  r_origin_y  <= i_cfg_data;
                CFG_TREE_SIZE: r_tree_size <= i_cfg_data[SizeW-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !w_busy;
    assign w_fire = s_axis_tvalid && s_axis_tready;

    ckd_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_fire(w_fire), .i_opcode(s_axis_tdata[1:0]),
        .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(w_busy),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready)
    );

    ckd_datapath #(.MAX_POINTS(MAX_POINTS), .CODE_BITS(CODE_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd(w_cmd), .o_sts(w_sts),
        .i_opcode(s_axis_tdata[1:0]),
        .i_entry_index(s_axis_tdata[2 +: SizeW]),
        .i_code_value(s_axis_tdata[2 + SizeW +: CODE_BITS]),
        .i_query_x(s_axis_tdata[QX +: CoordW]),
        .i_query_y(s_axis_tdata[QX + CoordW +: CoordW]),
        .i_wr(w_fire),
        .i_origin_x(r_origin_x), .i_origin_y(r_origin_y), .i_tree_size(r_tree_size),
        .o_found(w_found), .o_point_x(w_px), .o_point_y(w_py)
    );

    assign m_axis_tdata = {7'd0, w_py, w_px, w_found};
endmodule

### hw/rtl/ckd_checker.sv
`include "assert_macros.svh"
module ckd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    `CKD_ASSERT(a_no_accept_while_result, i_clk, i_rst_n, m_axis_tvalid |-> !s_axis_tready, "input taken while result waits")
    `CKD_ASSERT(a_miss_zero, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[64:1] == 64'd0), "miss carries nonzero point")
    `CKD_ASSERT(a_result_holds, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")
    `CKD_ASSERT(a_ready_after_out, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tready) |=> s_axis_tready, "not ready after result transfer")
endmodule

bind compact_kd_tree_point_lookup ckd_checker u_ckd_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

### test/compact_kd_tree_point_lookup_test.sv
module compact_kd_tree_point_lookup_test;
    import ckd_pkg::*;

    localparam int InW       = ((2 + SizeW + CodeBits + 64 + 7) / 8) * 8;
    localparam int WatchMax  = 20000;
    localparam int DrainWait = 300;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        bit          found;
        logic [31:0] x;
        logic [31:0] y;
    } t_answer;

    // Mirror of the block: code store, origin and size, plus the answers still owed.
    class kd_answer_board;
        logic [23:0] codes [1:MaxPoints];
        logic [31:0] org_x;
        logic [31:0] org_y;
        logic [10:0] size;
        t_answer     owed [$];
        int          errors;

        function new();
            org_x  = '0;
            org_y  = '0;
            size   = '0;
            errors = 0;
        endfunction

        function void configure(logic [CfgIdxW-1:0] r, logic [31:0] v);
            case (r)
                CFG_ORIGIN_X:  org_x = v;
                CFG_ORIGIN_Y:  org_y = v;
                CFG_TREE_SIZE: size  = v[10:0];
                default: ;
            endcase
        endfunction

        function int live_size();
            return (size > MaxPoints) ? MaxPoints : int'(size);
        endfunction

        function logic [31:0] int_root(logic [31:0] v);
            logic [31:0] r;
            logic [31:0] t;
            r = 0;
            for (int b = 15; b >= 0; b--) begin
                t = r | (32'd1 << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        // Spiral offset from the parent point; code zero is the parent itself.
        function void unspiral(logic [23:0] code, logic [31:0] px, logic [31:0] py,
                               output logic [31:0] ox, output logic [31:0] oy);
            logic [31:0] s, len, m, d, zone, c;
            c = {8'd0, code};
            if (c == 0) begin
                ox = px;
                oy = py;
                return;
            end
            s    = int_root(c);
            len  = s + 1 + (s & 1);
            m    = (len - 1) >> 1;
            d    = c - (len - 2) * (len - 2);
            zone = d / (len - 1);
            case (zone)
                0: begin ox = px + m;                 oy = py + m - d; end
                1: begin ox = px + (len - 1) + m - d; oy = py - m; end
                2: begin ox = px - m;                 oy = py + d - m - 2 * (len - 1); end
                default: begin ox = px + d - m - 3 * (len - 1); oy = py + m; end
            endcase
        endfunction

        // Walk by position; caller keeps idx within 1..live_size.
        function void point_at(int idx, output logic [31:0] x, output logic [31:0] y);
            int lo, hi, mid;
            logic [31:0] px, py;
            lo = 1;
            hi = live_size();
            px = org_x;
            py = org_y;
            forever begin
                mid = (lo + hi) / 2;
                unspiral(codes[mid], px, py, x, y);
                if (mid == idx) return;
                if (idx < mid) hi = mid - 1;
                else lo = mid + 1;
                px = x;
                py = y;
            end
        endfunction

        function void note_input(logic [1:0] op, logic [10:0] idx, logic [23:0] code,
                                 logic [31:0] qx, logic [31:0] qy);
            t_answer a;
            int lo, hi, mid;
            bit on_x;
            logic [31:0] px, py, nx, ny;
            a.found = 0;
            a.x     = '0;
            a.y     = '0;
            if (op == OP_WRITE) begin
                if (idx >= 1 && idx <= MaxPoints) codes[idx] = code;
                return;
            end
            if (op != OP_LOOKUP && op != OP_ACCESS) return;
            if (op == OP_LOOKUP) begin
                lo   = 1;
                hi   = live_size();
                px   = org_x;
                py   = org_y;
                on_x = 1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    unspiral(codes[mid], px, py, nx, ny);
                    if (nx == qx && ny == qy) begin
                        a.found = 1;
                        a.x     = qx;
                        a.y     = qy;
                        break;
                    end
                    // equality goes left
                    if (on_x ? ($signed(qx) <= $signed(nx)) : ($signed(qy) <= $signed(ny)))
                        hi = mid - 1;
                    else
                        lo = mid + 1;
                    px   = nx;
                    py   = ny;
                    on_x = !on_x;
                end
            end else if (idx >= 1 && idx <= live_size()) begin
                a.found = 1;
                point_at(int'(idx), a.x, a.y);
            end
            owed.push_back(a);
        endfunction

        function void check_result(bit found, logic [31:0] x, logic [31:0] y);
            t_answer a;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result found=%0b x=%h y=%h", $time, found, x, y);
                errors++;
                return;
            end
            a = owed.pop_front();
            if (found !== a.found) begin
                $display("%0t: found expected %0b actual %0b", $time, a.found, found);
                errors++;
            end
            if (x !== a.x) begin
                $display("%0t: point_x expected %h actual %h", $time, a.x, x);
                errors++;
            end
            if (y !== a.y) begin
                $display("%0t: point_y expected %h actual %h", $time, a.y, y);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [InW-1:0]   s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [71:0]      m_axis_tdata;
    logic             i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [31:0]      i_cfg_data;

    kd_answer_board board;
    bit             written [1:MaxPoints];
    bit             calm;       // no idling on either side while set
    int             rx_hold;
    int             quiet_cycles;
    int             items_sent;

    compact_kd_tree_point_lookup DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver: after each transfer, hold tready low for the random hold count rx_hold, zero while calm.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready = 1'b0;
            rx_hold--;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[64:33]);
            rx_hold = calm ? 0 : $urandom_range(0, 7);
        end
    end

    // Watchdog: count cycles in which no transfer and no register write happens.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchMax) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [10:0] idx, logic [23:0] code,
                             logic [31:0] qx, logic [31:0] qy);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = '0;
        s_axis_tdata[1:0]    = op;
        s_axis_tdata[12:2]   = idx;
        s_axis_tdata[36:13]  = code;
        s_axis_tdata[68:37]  = qx;
        s_axis_tdata[100:69] = qy;
        s_axis_tvalid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        board.note_input(op, idx, code, qx, qy);
        if (op == OP_WRITE && idx >= 1 && idx <= MaxPoints) written[idx] = 1;
        items_sent++;
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] r, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = r;
        i_cfg_data  = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        board.configure(r, v);
    endtask

    // Hold the sender until every answer is in, then let a trailing write settle.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (board.owed.size() != 0) @(negedge i_clk);
        repeat (DrainWait) @(negedge i_clk);
    endtask

    task automatic set_tree(logic [31:0] ox, logic [31:0] oy, logic [10:0] n);
        drain();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_TREE_SIZE, {21'd0, n});
    endtask

    function automatic logic [23:0] pick_code();
        case ($urandom_range(0, 5))
            0:       return 24'd0;
            1, 2:    return 24'($urandom_range(1, 60));
            3:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // Fill every live position that has never been written, so no walk reads junk.
    task automatic fill_tree();
        for (int i = 1; i <= board.live_size(); i++)
            if (!written[i]) send_item(OP_WRITE, 11'(i), pick_code(), $urandom, $urandom);
    endtask

    task automatic lookup_near(int n);
        logic [31:0] x, y;
        if (n == 0) begin
            send_item(OP_LOOKUP, 11'($urandom), 24'($urandom), $urandom, $urandom);
            return;
        end
        board.point_at(int'($urandom_range(1, n)), x, y);
        case ($urandom_range(0, 3))
            0: x = x + 1;
            1: y = y - 1;
            default: ;
        endcase
        send_item(OP_LOOKUP, 11'($urandom), 24'($urandom), x, y);
    endtask

    task automatic random_phase(int ops);
        int n, pick;
        n = board.live_size();
        fill_tree();
        for (int k = 0; k < ops; k++) begin
            if (($urandom_range(0, 15)) == 0) calm = !calm;
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                if ($urandom_range(0, 4) == 0)
                    send_item(OP_LOOKUP, 11'($urandom), 24'($urandom), $urandom, $urandom);
                else
                    lookup_near(n);
            end else if (pick < 15) begin
                if (n > 0 && $urandom_range(0, 5) != 0)
                    send_item(OP_ACCESS, 11'($urandom_range(1, n)), 24'($urandom), $urandom,
                              $urandom);
                else
                    send_item(OP_ACCESS, 11'($urandom_range(n + 1, 2047)), 24'($urandom),
                              $urandom, $urandom);
            end else if (pick < 18) begin
                // rewrite a live entry or seed one outside the tree
                send_item(OP_WRITE, 11'($urandom_range(1, MaxPoints)), pick_code(), $urandom,
                          $urandom);
            end else if (pick == 18) begin
                send_item(OP_WRITE, ($urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(1025,
                          2047))), pick_code(), $urandom, $urandom);
            end else begin
                send_item(OP_UNUSED, 11'($urandom), 24'($urandom), $urandom, $urandom);
            end
        end
    endtask

    initial begin
        logic [10:0] n;
        board         = new();
        calm          = 0;
        rx_hold       = 0;
        quiet_cycles  = 0;
        items_sent    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty tree straight after reset.
        send_item(OP_LOOKUP, 11'd1, 24'd0, 32'd0, 32'd0);
        send_item(OP_ACCESS, 11'd1, 24'd0, 32'd0, 32'd0);
        send_item(OP_UNUSED, 11'h7FF, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        // Seed a seven-entry tree with code extremes, plus writes that must be dropped.
        send_item(OP_WRITE, 11'd1, 24'd0, 32'd0, 32'd0);
        send_item(OP_WRITE, 11'd2, 24'hFFFFFF, 32'd0, 32'd0);
        send_item(OP_WRITE, 11'd3, 24'd1, 32'd0, 32'd0);
        send_item(OP_WRITE, 11'd4, 24'd9, 32'd0, 32'd0);
        send_item(OP_WRITE, 11'd5, 24'd2, 32'd0, 32'd0);
        send_item(OP_WRITE, 11'd6, 24'd25, 32'd0, 32'd0);
        send_item(OP_WRITE, 11'd7, 24'h800000, 32'd0, 32'd0);
        send_item(OP_WRITE, 11'd0, 24'd5, 32'd0, 32'd0);
        send_item(OP_WRITE, 11'h7FF, 24'd5, 32'd0, 32'd0);
        send_item(OP_WRITE, 11'd1025, 24'd5, 32'd0, 32'd0);
        // Origin at the signed extremes so offsets wrap.
        set_tree(32'h7FFFFFFF, 32'h80000000, 11'd7);
        lookup_near(7);
        lookup_near(7);
        send_item(OP_LOOKUP, 11'd0, 24'd0, 32'h80000000, 32'h7FFFFFFF);
        send_item(OP_ACCESS, 11'd4, 24'd0, 32'd0, 32'd0);
        send_item(OP_ACCESS, 11'd7, 24'd0, 32'd0, 32'd0);
        send_item(OP_ACCESS, 11'd1, 24'd0, 32'd0, 32'd0);
        send_item(OP_ACCESS, 11'd0, 24'd0, 32'd0, 32'd0);
        send_item(OP_ACCESS, 11'd8, 24'd0, 32'd0, 32'd0);
        send_item(OP_ACCESS, 11'h7FF, 24'd0, 32'd0, 32'd0);

        // Random phases; the largest and an oversized size come once each.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                4:       n = 11'd1024;
                8:       n = 11'h7FF;
                10:      n = 11'd0;
                default: n = 11'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 3))
                0:       set_tree(32'h80000000, 32'h7FFFFFFF, n);
                1:       set_tree(32'd0, 32'd0, n);
                default: set_tree($urandom, $urandom, n);
            endcase
            random_phase((ph == 4 || ph == 8) ? 10 : 5);
        end

        drain();
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

### compact_kd_tree_point_lookup.f
+incdir+hw/rtl
hw/rtl/ckd_pkg.sv
hw/rtl/ckd_datapath.sv
hw/rtl/ckd_ctrl.sv
hw/rtl/compact_kd_tree_point_lookup.sv
hw/rtl/ckd_checker.sv
test/compact_kd_tree_point_lookup_test.sv
